FILE: rtl/ntkt_pkg.sv
// Shared types and constants for the nibble trie key table.
package ntkt_pkg;

   localparam int FANOUT = 16;
   localparam int NIB_W  = 4;

   // operation codes on req_func (code three behaves as find)
   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_FIND   = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   typedef enum logic [1:0] {
      OUT_WALKING = 2'd0,
      OUT_PREFIX  = 2'd1,
      OUT_MISSING = 2'd2,
      OUT_FULL    = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PREFIX,
      ST_LOOK,
      ST_FINISH,
      ST_RESULT
   } state_type;

   // memory strobes from the walker to the node store
   typedef struct packed {
      logic child_rd;
      logic child_wr;
      logic used_rd;
      logic used_wr;
      logic used_wr_val;
   } mem_ctl_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] node_id;
   } res_type;

endpackage

FILE: rtl/ntkt_node_store.sv
// Child table and used-mark memories with the post-reset clearing sweep.
module ntkt_node_store #(
   parameter int NODE_COUNT = 256,
   localparam int NW = $clog2(NODE_COUNT),
   localparam int AW = NW + 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ntkt_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]         child_rd_addr,
   input  logic [AW-1:0]         child_wr_addr,
   input  logic [NW-1:0]         child_wr_data,
   input  logic [NW-1:0]         used_addr,
   output logic [NW-1:0]         child_rd_data,
   output logic                  used_rd_data,
   output logic                  clear_busy
);
   import ntkt_pkg::*;

   localparam int DEPTH = NODE_COUNT * FANOUT;

   logic [NW-1:0] child_mem [DEPTH];
   logic          used_mem  [NODE_COUNT];

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0] child_rd_ff;
   logic          used_rd_ff;

   logic          cw_en, uw_en, uw_val;
   logic [AW-1:0] cw_addr;
   logic [NW-1:0] cw_data, uw_addr;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // sweep owns the write ports while clearing
   always_comb begin
      if (clearing_ff) begin
         cw_en   = 1'b1;
         cw_addr = clr_cnt_ff;
         cw_data = '0;
         uw_en   = (clr_cnt_ff < AW'(NODE_COUNT));
         uw_addr = clr_cnt_ff[NW-1:0];
         uw_val  = 1'b0;
      end else begin
         cw_en   = mem_ctl.child_wr;
         cw_addr = child_wr_addr;
         cw_data = child_wr_data;
         uw_en   = mem_ctl.used_wr;
         uw_addr = used_addr;
         uw_val  = mem_ctl.used_wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cw_en) begin
         child_mem[cw_addr] <= cw_data;
      end
      if (mem_ctl.child_rd) begin
         child_rd_ff <= child_mem[child_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (uw_en) begin
         used_mem[uw_addr] <= uw_val;
      end
      if (mem_ctl.used_rd) begin
         used_rd_ff <= used_mem[used_addr];
      end
   end

   assign child_rd_data = child_rd_ff;
   assign used_rd_data  = used_rd_ff;
   assign clear_busy    = clearing_ff;

endmodule

FILE: rtl/ntkt_walker.sv
// Sequencer that walks key nibbles through the child table and forms results.
module ntkt_walker #(
   parameter int NODE_COUNT = 256,
   localparam int NW = $clog2(NODE_COUNT),
   localparam int AW = NW + 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             func,
   input  logic [7:0]             key_byte,
   input  logic                   key_last,
   input  logic                   first_prefix,
   input  logic [NW-1:0]          child_rd_data,
   input  logic                   used_rd_data,
   input  logic                   out_free,
   output logic                   busy,
   output ntkt_pkg::mem_ctl_type  mem_ctl,
   output logic [AW-1:0]          child_rd_addr,
   output logic [AW-1:0]          child_wr_addr,
   output logic [NW-1:0]          child_wr_data,
   output logic [NW-1:0]          used_addr,
   output logic                   res_valid,
   output ntkt_pkg::res_type      res
);
   import ntkt_pkg::*;

   state_type     state_ff, state_in;
   outcome_type   outcome_ff, outcome_in;
   logic [NW-1:0] walk_node_ff, walk_node_in;
   logic [NW-1:0] hit_node_ff, hit_node_in;
   logic          ended_ff, ended_in;
   logic [NW:0]   alloc_ff, alloc_in;
   logic          nib_hi_ff, nib_hi_in;
   logic [1:0]    func_ff, func_in;
   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;
   logic          prefix_ff, prefix_in;

   logic          adding, removing, step_ok;
   logic [3:0]    cur_nib;
   logic [NW-1:0] nxt_node, end_node;

   assign adding   = (func_ff == FUNC_ADD);
   assign removing = (func_ff == FUNC_REMOVE);
   assign cur_nib  = nib_hi_ff ? byte_ff[7:4] : byte_ff[3:0];
   assign end_node = (outcome_ff == OUT_PREFIX) ? hit_node_ff : walk_node_ff;

   always_comb begin
      state_in      = state_ff;
      outcome_in    = outcome_ff;
      walk_node_in  = walk_node_ff;
      hit_node_in   = hit_node_ff;
      ended_in      = ended_ff;
      alloc_in      = alloc_ff;
      nib_hi_in     = nib_hi_ff;
      func_in       = func_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      prefix_in     = prefix_ff;
      mem_ctl       = '0;
      child_rd_addr = {walk_node_ff, byte_ff[3:0]};
      child_wr_addr = {walk_node_ff, cur_nib};
      child_wr_data = alloc_ff[NW-1:0];
      used_addr     = end_node;
      res_valid     = 1'b0;
      res           = '0;
      step_ok       = 1'b0;
      nxt_node      = child_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in   = func;
               byte_in   = key_byte;
               last_in   = key_last;
               prefix_in = first_prefix;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!ended_ff && outcome_ff == OUT_WALKING) begin
               if (byte_ff == 8'd0) begin
                  ended_in = 1'b1;
                  state_in = ST_FINISH;
               end else if (!adding && prefix_ff) begin
                  mem_ctl.used_rd = 1'b1;
                  used_addr       = walk_node_ff;
                  state_in        = ST_PREFIX;
               end else begin
                  mem_ctl.child_rd = 1'b1;
                  nib_hi_in        = 1'b0;
                  state_in         = ST_LOOK;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_PREFIX: begin
            if (used_rd_data) begin
               outcome_in  = OUT_PREFIX;
               hit_node_in = walk_node_ff;
               state_in    = ST_FINISH;
            end else begin
               mem_ctl.child_rd = 1'b1;
               nib_hi_in        = 1'b0;
               state_in         = ST_LOOK;
            end
         end
         ST_LOOK: begin
            priority if (child_rd_data != '0) begin
               step_ok = 1'b1;
            end else if (!adding) begin
               outcome_in = OUT_MISSING;
               state_in   = ST_FINISH;
            end else if (alloc_ff >= (NW+1)'(NODE_COUNT)) begin
               outcome_in = OUT_FULL;
               state_in   = ST_FINISH;
            end else begin
               // new node takes the next free id
               mem_ctl.child_wr = 1'b1;
               alloc_in         = alloc_ff + (NW+1)'(1);
               nxt_node         = alloc_ff[NW-1:0];
               step_ok          = 1'b1;
            end
            if (step_ok) begin
               walk_node_in = nxt_node;
               if (!nib_hi_ff) begin
                  mem_ctl.child_rd = 1'b1;
                  child_rd_addr    = {nxt_node, byte_ff[7:4]};
                  nib_hi_in        = 1'b1;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (last_ff) begin
               mem_ctl.used_rd = 1'b1;
               state_in        = ST_RESULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESULT: begin
            priority if (outcome_ff == OUT_FULL) begin
               res.status = STAT_FULL;
            end else if (outcome_ff == OUT_MISSING) begin
               res.status = STAT_MISS;
            end else if (adding) begin
               res.status  = STAT_OK;
               res.node_id = 8'(end_node);
            end else if (outcome_ff == OUT_PREFIX || used_rd_data) begin
               res.status  = STAT_OK;
               res.node_id = 8'(end_node);
            end else begin
               res.status = STAT_MISS;
            end
            if (out_free) begin
               res_valid = 1'b1;
               if (res.status == STAT_OK && adding) begin
                  mem_ctl.used_wr     = 1'b1;
                  mem_ctl.used_wr_val = 1'b1;
               end else if (res.status == STAT_OK && removing) begin
                  mem_ctl.used_wr     = 1'b1;
                  mem_ctl.used_wr_val = 1'b0;
               end
               walk_node_in = '0;
               hit_node_in  = '0;
               ended_in     = 1'b0;
               outcome_in   = OUT_WALKING;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         outcome_ff   <= OUT_WALKING;
         walk_node_ff <= '0;
         hit_node_ff  <= '0;
         ended_ff     <= 1'b0;
         alloc_ff     <= (NW+1)'(1);
         nib_hi_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         outcome_ff   <= outcome_in;
         walk_node_ff <= walk_node_in;
         hit_node_ff  <= hit_node_in;
         ended_ff     <= ended_in;
         alloc_ff     <= alloc_in;
         nib_hi_ff    <= nib_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      prefix_ff <= prefix_in;
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("item taken while walker busy");

   a_alloc_bound: assert property (@(posedge clock) disable iff (reset)
      alloc_ff <= (NW+1)'(NODE_COUNT) && alloc_ff != '0)
      else $error("node count out of range");

   a_wr_on_miss: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.child_wr |-> state_ff == ST_LOOK && child_rd_data == '0 && adding)
      else $error("child written without a missing child");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.child_wr |=> alloc_ff == $past(alloc_ff) + (NW+1)'(1))
      else $error("allocation did not advance node count");

   a_res_free: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free && state_ff == ST_RESULT && last_ff)
      else $error("result issued into a full output stage");
`endif

endmodule

FILE: rtl/nibble_trie_key_table.sv
// Top level of the nibble trie key table: handshakes, output stage, sub-blocks.
// A 16-ary trie over NODE_COUNT nodes. A key arrives one byte per item, low
// nibble walked first, and ends at a zero byte or at the item with
// req_key_last set; the single result (status, node id) follows that last
// item. Add creates missing nodes and marks the end node used, reporting pool
// full if it runs out of ids; find reports the used end node (or with
// first_prefix the first used node met before a nonzero byte); remove does a
// find and clears the mark. After reset the block runs a clearing sweep over
// all NODE_COUNT*16 child-table entries (4096 at the default size) and holds
// req_stall high while it runs. Each item then steps through: take it,
// decide, read the child table once per nibble for the two dependent nibbles
// (after a used-mark read when first_prefix applies), finish, and on the last
// item read the used mark and load the result; a zero byte or an ended walk
// goes from decide straight to finish. The single read port of the child
// table and the second nibble's dependence on the first order the reads. A
// finished result waits in its own output register, so the next key can
// start while it is still stalled; only when an earlier result still sits
// there under rsp_stall does the last item wait for it to leave. Node ids
// above 255 are reported by their low eight bits.
module nibble_trie_key_table #(
   parameter int NODE_COUNT = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [7:0] req_key_byte,
   input  logic       req_key_last,
   input  logic       req_first_prefix,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_node_id
);
   import ntkt_pkg::*;

   localparam int NW = $clog2(NODE_COUNT);
   localparam int AW = NW + 4;

   mem_ctl_type   mem_ctl;
   res_type       res;
   logic          res_valid;
   logic          busy, clear_busy, start, out_free;
   logic [AW-1:0] child_rd_addr, child_wr_addr;
   logic [NW-1:0] child_wr_data, child_rd_data, used_addr;
   logic          used_rd_data;

   logic          rsp_valid_ff, rsp_valid_in;
   res_type       rsp_ff, rsp_in;

   // no item while the sweep runs or a key byte is in flight
   assign req_stall = busy | clear_busy;
   assign start     = req_valid & ~req_stall;

   // output stage frees up in the same cycle the item is taken
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   ntkt_walker #(.NODE_COUNT(NODE_COUNT)) u_walker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .func          (req_func),
      .key_byte      (req_key_byte),
      .key_last      (req_key_last),
      .first_prefix  (req_first_prefix),
      .child_rd_data (child_rd_data),
      .used_rd_data  (used_rd_data),
      .out_free      (out_free),
      .busy          (busy),
      .mem_ctl       (mem_ctl),
      .child_rd_addr (child_rd_addr),
      .child_wr_addr (child_wr_addr),
      .child_wr_data (child_wr_data),
      .used_addr     (used_addr),
      .res_valid     (res_valid),
      .res           (res)
   );

   ntkt_node_store #(.NODE_COUNT(NODE_COUNT)) u_store (
      .clock         (clock),
      .reset         (reset),
      .mem_ctl       (mem_ctl),
      .child_rd_addr (child_rd_addr),
      .child_wr_addr (child_wr_addr),
      .child_wr_data (child_wr_data),
      .used_addr     (used_addr),
      .child_rd_data (child_rd_data),
      .used_rd_data  (used_rd_data),
      .clear_busy    (clear_busy)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_ff.status;
   assign rsp_node_id = rsp_ff.node_id;

endmodule

FILE: tb/sv/nibble_trie_key_table_tb.sv
// Self-checking testbench for the nibble trie key table: directed keys, random traffic, pool exhaustion.
`timescale 1ns / 100ps

module nibble_trie_key_table_tb;
   import ntkt_pkg::*;

   localparam int NODES        = 256;
   localparam int LIB_KEYS     = 20;
   localparam int DRAIN_CYCLES = 16;
   // clearing sweep (NODES*16 entries) plus ~1300 items, with a wide margin
   localparam int CYCLE_LIMIT  = 200000;
   // func code three is not in the package; the block treats it as a find
   localparam logic [1:0] FUNC_FIND_ALIAS = 2'd3;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [1:0] req_func         = FUNC_ADD;
   logic [7:0] req_key_byte     = 8'h00;
   logic       req_key_last     = 1'b0;
   logic       req_first_prefix = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_node_id;

   nibble_trie_key_table #(.NODE_COUNT(NODES)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_key_byte     (req_key_byte),
      .req_key_last     (req_key_last),
      .req_first_prefix (req_first_prefix),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_node_id      (rsp_node_id)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Trie shadow: child entries hold child id + 1, zero meaning no child.
   // ---------------------------------------------------------------------
   int          child_tbl [NODES*16];
   bit          used_mark [NODES];
   int          pool_used;
   int          walk_node;
   bit          key_done;
   outcome_type walk_state;
   int          hit_node;

   res_type     want_q [$];   // results still owed by the block, oldest first

   // run bookkeeping
   int  errors;
   int  items_sent;
   int  keys_sent;
   int  results_seen;
   int  n_found;
   int  n_missing;
   int  n_full;
   int  cycle_cnt;
   bit  idle_on  = 1'b1;      // sender gaps between items
   bit  stall_on = 1'b1;      // receiver stalls between results
   int  stall_left;
   res_type got_res;
   res_type want_res;

   // library of keys that traffic keeps returning to, so walks go deep
   logic [7:0] lib_key [LIB_KEYS][4];
   int         lib_len [LIB_KEYS];

   function automatic void clear_walk();
      walk_node  = 0;
      key_done   = 1'b0;
      walk_state = OUT_WALKING;
      hit_node   = 0;
   endfunction

   // One trie level: follow the child, or create it when adding.
   function automatic void walk_one_nibble(input logic [3:0] nib, input bit adding);
      int slot;
      slot = walk_node * 16 + int'(nib);
      if (child_tbl[slot] == 0) begin
         if (!adding) begin
            walk_state = OUT_MISSING;
            return;
         end
         if (pool_used >= NODES) begin
            walk_state = OUT_FULL;
            return;
         end
         child_tbl[slot] = pool_used + 1;
         pool_used++;
      end
      walk_node = child_tbl[slot] - 1;
   endfunction

   // Apply one accepted item to the shadow trie; on the last item of a key
   // queue the result the block owes.
   function automatic void trie_apply_item(input logic [1:0] fn, input logic [7:0] kb,
                                           input logic last, input logic pfx);
      bit      adding;
      int      n;
      res_type r;
      adding = (fn == FUNC_ADD);
      if (!key_done && walk_state == OUT_WALKING) begin
         if (kb == 8'h00) begin
            key_done = 1'b1;
         end else if (!adding && pfx && used_mark[walk_node]) begin
            // first used prefix met before a nonzero byte
            walk_state = OUT_PREFIX;
            hit_node   = walk_node;
         end else begin
            walk_one_nibble(kb[3:0], adding);
            if (walk_state == OUT_WALKING) walk_one_nibble(kb[7:4], adding);
         end
      end
      if (!last) return;

      r.status  = STAT_MISS;
      r.node_id = 8'h00;
      if (walk_state == OUT_FULL) begin
         r.status = STAT_FULL;
      end else if (walk_state != OUT_MISSING) begin
         n = (walk_state == OUT_PREFIX) ? hit_node : walk_node;
         if (adding) begin
            used_mark[n] = 1'b1;
            r.status     = STAT_OK;
            r.node_id    = n[7:0];
         end else if (walk_state == OUT_PREFIX || used_mark[n]) begin
            r.status  = STAT_OK;
            r.node_id = n[7:0];
            if (fn == FUNC_REMOVE) used_mark[n] = 1'b0;
         end
      end
      case (r.status)
         STAT_OK:   n_found++;
         STAT_FULL: n_full++;
         default:   n_missing++;
      endcase
      want_q = {want_q, r};
      clear_walk();
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Sender: one item per call. Valid is left high on return so that a
   // back-to-back item never sees valid dropped and raised in one step.
   // ---------------------------------------------------------------------
   task automatic send_item(input logic [1:0] fn, input logic [7:0] kb,
                            input logic last, input logic pfx);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= fn;
      req_key_byte     <= kb;
      req_key_last     <= last;
      req_first_prefix <= pfx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trie_apply_item(fn, kb, last, pfx);
      items_sent++;
   endtask

   // A whole key: its bytes, then optionally a zero byte and junk that the
   // block must ignore. Mixed keys draw a fresh func per item.
   task automatic send_key(input logic [7:0] kb [4], input int len, input logic [1:0] fn,
                           input bit mix, input int junk);
      int         total;
      logic [7:0] b;
      logic [1:0] f;
      total = len + junk;
      keys_sent++;
      for (int i = 0; i < total; i++) begin
         if (i < len)       b = kb[i];
         else if (i == len) b = 8'h00;
         else               b = 8'($urandom_range(0, 255));
         f = mix ? 2'($urandom_range(0, 3)) : fn;
         send_item(f, b, i == total - 1, $urandom_range(0, 2) == 0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: checks each accepted result and draws a stall before the next.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            got_res.status  = rsp_status;
            got_res.node_id = rsp_node_id;
            if (want_q.size() == 0) begin
               report_mismatch("result with none outstanding, status", got_res.status, -1);
            end else begin
               want_res = want_q.pop_front();
               if (got_res.status != want_res.status)
                  report_mismatch("status", got_res.status, want_res.status);
               if (got_res.node_id != want_res.node_id)
                  report_mismatch("node_id", got_res.node_id, want_res.node_id);
            end
            stall_left = stall_on ? $urandom_range(0, 3) : 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("[%0t] watchdog expired, %0d results outstanding", $realtime, want_q.size());
         $display("nibble_trie_key_table_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty key: zero byte ends it at the root.
   task automatic test_empty_key();
      send_item(FUNC_FIND,   8'h00, 1'b1, 1'b0);   // root not yet used: miss
      send_item(FUNC_ADD,    8'h00, 1'b1, 1'b0);   // marks the root
      send_item(FUNC_FIND,   8'h00, 1'b1, 1'b0);
      send_item(FUNC_REMOVE, 8'h00, 1'b1, 1'b0);
      send_item(FUNC_FIND,   8'h00, 1'b1, 1'b0);   // cleared again
   endtask

   // Byte extremes, the func alias, an unused inner node and a missing child.
   task automatic test_extreme_bytes();
      send_item(FUNC_ADD,        8'hFF, 1'b0, 1'b0);
      send_item(FUNC_ADD,        8'h01, 1'b1, 1'b0);
      send_item(FUNC_FIND_ALIAS, 8'hFF, 1'b0, 1'b0);
      send_item(FUNC_FIND_ALIAS, 8'h01, 1'b1, 1'b0);
      send_item(FUNC_FIND,       8'hFF, 1'b1, 1'b0);   // node exists but unused
      send_item(FUNC_FIND,       8'h01, 1'b1, 1'b0);   // no such child
   endtask

   // Prefix stop: with the root used, a prefix find halts at the root.
   task automatic test_prefix_stop();
      send_item(FUNC_ADD,    8'h00, 1'b1, 1'b0);
      send_item(FUNC_FIND,   8'h80, 1'b0, 1'b1);
      send_item(FUNC_FIND,   8'h7F, 1'b1, 1'b1);
      send_item(FUNC_REMOVE, 8'hFF, 1'b0, 1'b0);
      send_item(FUNC_REMOVE, 8'h01, 1'b1, 1'b0);
   endtask

   // Bytes after a zero are ignored; a key may change func part way.
   task automatic test_trailing_and_mixed();
      send_item(FUNC_ADD,  8'h12, 1'b0, 1'b0);
      send_item(FUNC_ADD,  8'h00, 1'b0, 1'b0);
      send_item(FUNC_ADD,  8'h34, 1'b1, 1'b0);
      send_item(FUNC_FIND, 8'h12, 1'b0, 1'b0);
      send_item(FUNC_FIND, 8'h00, 1'b1, 1'b0);
      send_item(FUNC_FIND, 8'h12, 1'b0, 1'b0);
      send_item(FUNC_ADD,  8'h56, 1'b1, 1'b0);   // result follows the last func
   endtask

   // Random keys: mostly library keys (whole or truncated), some noise keys.
   task automatic random_traffic(input int target);
      int         stop_at;
      int         k;
      int         len;
      int         junk;
      bit         mix;
      logic [1:0] fn;
      logic [7:0] kb [4];
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         // stretches with no sender gaps and with no receiver stalls
         idle_on  = ((keys_sent / 64) % 4) != 3;
         stall_on = ((keys_sent / 48) % 4) != 2;
         fn   = 2'($urandom_range(0, 3));
         mix  = $urandom_range(0, 9) == 0;
         junk = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
         if ($urandom_range(0, 99) < 80) begin
            k   = $urandom_range(0, LIB_KEYS - 1);
            kb  = lib_key[k];
            len = lib_len[k];
            if (len > 1 && $urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
         end else begin
            len = $urandom_range(1, 2);
            for (int i = 0; i < 4; i++) kb[i] = 8'($urandom_range(0, 255));
         end
         send_key(kb, len, fn, mix, junk);
      end
   endtask

   task automatic test_library_traffic();
      for (int k = 0; k < LIB_KEYS; k++) begin
         lib_len[k] = $urandom_range(1, 3);
         for (int i = 0; i < 4; i++) lib_key[k][i] = 8'($urandom_range(1, 255));
         send_key(lib_key[k], lib_len[k], FUNC_ADD, 1'b0, 0);
      end
      random_traffic(800);
   endtask

   // Long distinct keys until the pool runs dry, a few more adds that must
   // report it full, then ordinary traffic on the full pool.
   task automatic test_pool_exhaustion();
      int         extra;
      int         guard;
      logic [7:0] kb [4];
      extra = 0;
      guard = 0;
      while (extra < 6 && guard < 150) begin
         guard++;
         if (pool_used >= NODES) extra++;
         for (int i = 0; i < 4; i++)
            kb[i] = {4'($urandom_range(1, 15)), 4'($urandom_range(1, 15))};
         send_key(kb, 4, FUNC_ADD, 1'b0, 0);
      end
      random_traffic(200);
   endtask

   initial begin
      for (int i = 0; i < NODES * 16; i++) child_tbl[i] = 0;
      for (int i = 0; i < NODES; i++) used_mark[i] = 1'b0;
      pool_used = 1;   // root only
      clear_walk();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // the clearing sweep after reset shows up as req_stall; send_item waits it out
      test_empty_key();
      test_extreme_bytes();
      test_prefix_stop();
      test_trailing_and_mixed();
      test_library_traffic();
      test_pool_exhaustion();

      req_valid <= 1'b0;
      while (want_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d keys in %0d items, %0d nodes of %0d allocated",
               keys_sent, items_sent, pool_used, NODES);
      $display("checked %0d results: %0d found, %0d not found, %0d pool full",
               results_seen, n_found, n_missing, n_full);
      if (errors == 0) begin
         $display("nibble_trie_key_table_tb: clean");
      end else begin
         $display("nibble_trie_key_table_tb: errors");
      end
      $finish;
   end

endmodule
